// ===== sv/mcid_pkg.sv =====
// ----------------------------------------------------------------------------
// mcid_pkg
// Shared types and constants for the multi-channel input debouncer.
// ----------------------------------------------------------------------------
package mcid_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

	// Widths fixed by the field list
	localparam int TIME_W  = 32;
	localparam int LEVEL_W = 8;
	localparam int DELAY_W = 16;
	localparam int SEL_W   = 3;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 16;

	// Register reset values
	localparam logic [LEVEL_W-1:0] NC_MASK_RST        = 8'd0;
	localparam logic [SEL_W-1:0]   EXTEND_CHANNEL_RST  = 3'd4;
	localparam logic [SEL_W-1:0]   RETRACT_CHANNEL_RST = 3'd5;
	localparam logic [DELAY_W-1:0] EXTEND_DELAY_RST    = 16'd10;
	localparam logic [DELAY_W-1:0] RETRACT_DELAY_RST   = 16'd10;
	localparam logic [DELAY_W-1:0] BUTTON_DELAY_RST    = 16'd50;

	typedef enum logic [IDX_W-1:0] {
		CFG_NC_MASK          = 3'd0,
		CFG_EXTEND_CHANNEL   = 3'd1,
		CFG_RETRACT_CHANNEL  = 3'd2,
		CFG_EXTEND_DELAY     = 3'd3,
		CFG_RETRACT_DELAY    = 3'd4,
		CFG_BUTTON_DELAY     = 3'd5
	} cfg_index_t;

	// One state memory entry per channel
	typedef struct packed {
		logic              stable;
		logic              last;
		logic [TIME_W-1:0] change_time;
	} entry_t;

	// Result word, debounced states in the low byte
	typedef struct packed {
		logic [LEVEL_W-1:0] changed_mask;
		logic [LEVEL_W-1:0] debounced_states;
	} result_t;

endpackage

// ===== sv/multi_channel_input_debouncer.sv =====
// ----------------------------------------------------------------------------
// multi_channel_input_debouncer
// Timestamp-based switch debouncer over a set of channels.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one poll: a millisecond timestamp and
// the raw pin levels. Each poll yields exactly one result on the master
// stream with the debounced state vector and a mask of channels that changed.
// The configuration port holds the normally-closed mask, the two limit switch
// channel numbers and the three delays. The user must write it only while no
// poll is open; the block does not enforce this. Per-channel state (stable
// flag, last active flag, time of last change) is kept in a small synchronous
// RAM that is read, updated and written back one channel per cycle. A new
// poll is taken while the last channel of the previous one is read, so a
// poll can be taken before the previous one is through. Results pass through
// a two-entry buffer, and at most two polls may be open between input and
// output; when the receiver stalls with both taken, s_tready drops until a
// result is collected.
// Reset clears the configuration to its defaults and marks every memory entry
// as unwritten, which reads as inactive with a change time of zero; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_channel_input_debouncer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [mcid_pkg::IN_W-1:0]   s_tdata,   // now_ms[31:0], raw_levels[39:32]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mcid_pkg::OUT_W-1:0]  m_tdata,   // debounced_states[7:0], changed_mask[15:8]
	input  logic                        cfg_wr_en,
	input  logic [mcid_pkg::IDX_W-1:0]  cfg_index,
	input  logic [mcid_pkg::CFG_W-1:0]  cfg_wdata
);

	// Configuration registers
	logic [mcid_pkg::LEVEL_W-1:0] nc_mask_q;
	logic [mcid_pkg::SEL_W-1:0]   extend_channel_q;
	logic [mcid_pkg::SEL_W-1:0]   retract_channel_q;
	logic [mcid_pkg::DELAY_W-1:0] extend_delay_q;
	logic [mcid_pkg::DELAY_W-1:0] retract_delay_q;
	logic [mcid_pkg::DELAY_W-1:0] button_delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_mask_q         <= mcid_pkg::NC_MASK_RST;
			extend_channel_q  <= mcid_pkg::EXTEND_CHANNEL_RST;
			retract_channel_q <= mcid_pkg::RETRACT_CHANNEL_RST;
			extend_delay_q    <= mcid_pkg::EXTEND_DELAY_RST;
			retract_delay_q   <= mcid_pkg::RETRACT_DELAY_RST;
			button_delay_q    <= mcid_pkg::BUTTON_DELAY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mcid_pkg::CFG_NC_MASK:         nc_mask_q         <= cfg_wdata[7:0];
				mcid_pkg::CFG_EXTEND_CHANNEL:  extend_channel_q  <= cfg_wdata[2:0];
				mcid_pkg::CFG_RETRACT_CHANNEL: retract_channel_q <= cfg_wdata[2:0];
				mcid_pkg::CFG_EXTEND_DELAY:    extend_delay_q    <= cfg_wdata;
				mcid_pkg::CFG_RETRACT_DELAY:   retract_delay_q   <= cfg_wdata;
				mcid_pkg::CFG_BUTTON_DELAY:    button_delay_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Issue stage: walks the channels of the current poll
	// ------------------------------------------------------------------
	logic                         busy_q;
	logic [mcid_pkg::CH_W-1:0]    ch_q;
	logic [mcid_pkg::TIME_W-1:0]  now_q;
	logic [mcid_pkg::LEVEL_W-1:0] levels_q;
	logic [1:0]                   open_q;     // polls accepted, result not yet taken
	logic                         issue_free;
	logic                         s_accept;
	logic                         m_accept;

	assign issue_free = !busy_q || (ch_q == mcid_pkg::CH_LAST);
	assign s_tready   = issue_free && (open_q != 2'd2);
	assign s_accept   = s_tvalid && s_tready;
	assign m_accept   = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ch_q   <= '0;
			open_q <= 2'd0;
		end else begin
			if (s_accept) begin
				busy_q <= 1'b1;
				ch_q   <= '0;
			end else if (busy_q) begin
				if (ch_q == mcid_pkg::CH_LAST) begin
					busy_q <= 1'b0;
				end
				ch_q <= ch_q + mcid_pkg::CH_W'(1);
			end
			case ({s_accept, m_accept})
				2'b10:   open_q <= open_q + 2'd1;
				2'b01:   open_q <= open_q - 2'd1;
				default: open_q <= open_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			now_q    <= s_tdata[31:0];
			levels_q <= s_tdata[39:32];
		end
	end

	// Per-channel inputs worked out while the memory read is in flight.
	// Channels beyond the eighth see a low level and a clear mask bit.
	logic [31:0]                  ch_ext;
	logic                         level_bit;
	logic                         nc_bit;
	logic                         active_now;
	logic [mcid_pkg::DELAY_W-1:0] delay_now;

	always_comb begin
		ch_ext    = 32'(ch_q);
		level_bit = 1'b0;
		nc_bit    = 1'b0;
		if (ch_ext < 32'd8) begin
			level_bit = levels_q[ch_ext[2:0]];
			nc_bit    = nc_mask_q[ch_ext[2:0]];
		end
		active_now = nc_bit ? level_bit : ~level_bit;
		if (ch_ext == 32'(extend_channel_q)) begin
			delay_now = extend_delay_q;
		end else if (ch_ext == 32'(retract_channel_q)) begin
			delay_now = retract_delay_q;
		end else begin
			delay_now = button_delay_q;
		end
	end

	// ------------------------------------------------------------------
	// State memory and stage 1: read-modify-write of one channel
	// ------------------------------------------------------------------
	logic                         valid_s1;
	logic                         first_s1;
	logic                         last_s1;
	logic [mcid_pkg::CH_W-1:0]    ch_s1;
	logic [mcid_pkg::TIME_W-1:0]  now_s1;
	logic                         active_s1;
	logic [mcid_pkg::DELAY_W-1:0] delay_s1;
	logic                         written_s1;
	logic                         fwd_s1;
	mcid_pkg::entry_t             fwd_data_s1;
	logic [mcid_pkg::CHANNELS-1:0] written_q;

	mcid_pkg::entry_t rd_entry;
	mcid_pkg::entry_t cur_entry;
	mcid_pkg::entry_t new_entry;
	logic             changed_bit;
	logic [31:0]      elapsed;

	mcid_ram #(
		.WIDTH ($bits(mcid_pkg::entry_t)),
		.DEPTH (mcid_pkg::CHANNELS)
	) u_state_ram (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (ch_s1),
		.wr_data (new_entry),
		.rd_en   (busy_q),
		.rd_addr (ch_q),
		.rd_data (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			written_q <= '0;
		end else begin
			valid_s1 <= busy_q;
			if (valid_s1) begin
				written_q[ch_s1] <= 1'b1;
			end
		end
	end

	// A write in the same cycle as a read of the same entry is forwarded,
	// which only happens with a single channel.
	always_ff @(posedge clk) begin
		first_s1    <= (ch_q == '0);
		last_s1     <= (ch_q == mcid_pkg::CH_LAST);
		ch_s1       <= ch_q;
		now_s1      <= now_q;
		active_s1   <= active_now;
		delay_s1    <= delay_now;
		written_s1  <= written_q[ch_q];
		fwd_s1      <= valid_s1 && (ch_s1 == ch_q);
		fwd_data_s1 <= new_entry;
	end

	always_comb begin
		if (fwd_s1) begin
			cur_entry = fwd_data_s1;
		end else if (written_s1) begin
			cur_entry = rd_entry;
		end else begin
			cur_entry = '0;
		end
		new_entry = cur_entry;
		if (active_s1 != cur_entry.last) begin
			new_entry.last        = active_s1;
			new_entry.change_time = now_s1;
		end
		elapsed     = now_s1 - new_entry.change_time;
		changed_bit = 1'b0;
		if ((elapsed > 32'(delay_s1)) && (new_entry.last != new_entry.stable)) begin
			new_entry.stable = new_entry.last;
			changed_bit      = 1'b1;
		end
	end

	// Collect the result bits of the poll
	logic [mcid_pkg::LEVEL_W-1:0] states_q;
	logic [mcid_pkg::LEVEL_W-1:0] changed_q;
	logic [mcid_pkg::LEVEL_W-1:0] states_nxt;
	logic [mcid_pkg::LEVEL_W-1:0] changed_nxt;
	logic [mcid_pkg::LEVEL_W-1:0] bit_sel;
	logic [31:0]                  ch_ext_s1;

	always_comb begin
		ch_ext_s1 = 32'(ch_s1);
		bit_sel   = '0;
		if (ch_ext_s1 < 32'd8) begin
			bit_sel = 8'd1 << ch_ext_s1[2:0];
		end
		states_nxt  = first_s1 ? '0 : states_q;
		changed_nxt = first_s1 ? '0 : changed_q;
		if (new_entry.stable) begin
			states_nxt = states_nxt | bit_sel;
		end
		if (changed_bit) begin
			changed_nxt = changed_nxt | bit_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			states_q  <= states_nxt;
			changed_q <= changed_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Two-entry result buffer
	// ------------------------------------------------------------------
	mcid_pkg::result_t res_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        fill_q;
	logic              push;

	assign push = valid_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (m_accept) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, m_accept})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q[wr_ptr_q] <= '{changed_mask: changed_nxt, debounced_states: states_nxt};
		end
	end

	assign m_tvalid = (fill_q != 2'd0);
	assign m_tdata  = res_q[rd_ptr_q];

endmodule

// ===== sv/mcid_ram.sv =====
// ----------------------------------------------------------------------------
// mcid_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mcid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/mcid_checker.sv =====
// ----------------------------------------------------------------------------
// mcid_props
// Port-level checks for the multi-channel input debouncer.
// ----------------------------------------------------------------------------
module mcid_props (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [mcid_pkg::OUT_W-1:0]  m_tdata
);

	logic [2:0]                   open_q;
	logic [mcid_pkg::LEVEL_W-1:0] prev_states_q;
	logic                         s_accept;
	logic                         m_accept;

	assign s_accept = s_tvalid && s_tready;
	assign m_accept = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q        <= 3'd0;
			prev_states_q <= '0;
		end else begin
			case ({s_accept, m_accept})
				2'b10:   open_q <= open_q + 3'd1;
				2'b01:   open_q <= open_q - 3'd1;
				default: open_q <= open_q;
			endcase
			if (m_accept) begin
				prev_states_q <= m_tdata[7:0];
			end
		end
	end

	// A result never appears without a poll that is still open.
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (open_q != 3'd0))
		else $error("result presented with no open poll");

	// No more than two polls may be open at once.
	a_open_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(open_q >= 3'd2) |-> !s_tready)
		else $error("poll accepted beyond the result buffer");

	// Each change mask is exactly the difference from the previous state vector.
	a_change_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:8] == (m_tdata[7:0] ^ prev_states_q)))
		else $error("change mask disagrees with debounced states");

	// A stalled result holds.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed or vanished");

endmodule

bind multi_channel_input_debouncer mcid_props u_mcid_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/mcid_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcid_checker
// Watches the poll, result and register channels of the debouncer, predicts
// each result from its own copy of the channel state and compares.
// ----------------------------------------------------------------------------
module mcid_checker
	import mcid_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // now_ms[31:0], raw_levels[39:32]
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [OUT_W-1:0]   m_tdata,   // debounced_states[7:0], changed_mask[15:8]
	input  logic               cfg_wr_en,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	output int                 fail_count,
	output int                 pending_count,
	output int                 checked_count
);

	// Register copy
	logic [LEVEL_W-1:0] nc_bits;
	logic [SEL_W-1:0]   ext_sel;
	logic [SEL_W-1:0]   ret_sel;
	logic [DELAY_W-1:0] ext_hold;
	logic [DELAY_W-1:0] ret_hold;
	logic [DELAY_W-1:0] btn_hold;

	// Channel state copy
	logic [CHANNELS-1:0] settled;
	logic [CHANNELS-1:0] last_flag;
	logic [TIME_W-1:0]   change_at [CHANNELS];

	result_t expected_results [$];
	int      fails   = 0;
	int      checked = 0;

	assign fail_count    = fails;
	assign pending_count = expected_results.size();
	assign checked_count = checked;

	function automatic result_t debounce_poll(logic [TIME_W-1:0] now,
			logic [LEVEL_W-1:0] levels);
		result_t            res;
		logic               active;
		logic [DELAY_W-1:0] hold;
		logic [TIME_W-1:0]  elapsed;
		res = '0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			active = nc_bits[ch] ? levels[ch] : ~levels[ch];
			if (active != last_flag[ch]) begin
				change_at[ch] = now;
				last_flag[ch] = active;
			end
			// The extend channel wins when both limit switches name the same one.
			if (ch == ext_sel)
				hold = ext_hold;
			else if (ch == ret_sel)
				hold = ret_hold;
			else
				hold = btn_hold;
			elapsed = now - change_at[ch];
			if (elapsed > {16'd0, hold} && last_flag[ch] != settled[ch]) begin
				settled[ch] = last_flag[ch];
				res.changed_mask[ch] = 1'b1;
			end
			res.debounced_states[ch] = settled[ch];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			nc_bits   = NC_MASK_RST;
			ext_sel   = EXTEND_CHANNEL_RST;
			ret_sel   = RETRACT_CHANNEL_RST;
			ext_hold  = EXTEND_DELAY_RST;
			ret_hold  = RETRACT_DELAY_RST;
			btn_hold  = BUTTON_DELAY_RST;
			settled   = '0;
			last_flag = '0;
			for (int ch = 0; ch < CHANNELS; ch++)
				change_at[ch] = '0;
			expected_results.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index_t'(cfg_index))
					CFG_NC_MASK:         nc_bits  = cfg_wdata[LEVEL_W-1:0];
					CFG_EXTEND_CHANNEL:  ext_sel  = cfg_wdata[SEL_W-1:0];
					CFG_RETRACT_CHANNEL: ret_sel  = cfg_wdata[SEL_W-1:0];
					CFG_EXTEND_DELAY:    ext_hold = cfg_wdata[DELAY_W-1:0];
					CFG_RETRACT_DELAY:   ret_hold = cfg_wdata[DELAY_W-1:0];
					CFG_BUTTON_DELAY:    btn_hold = cfg_wdata[DELAY_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				if (expected_results.size() == 0) begin
					$error("unexpected result %04h with no poll outstanding", m_tdata);
					fails++;
				end else begin
					want = expected_results.pop_front();
					checked++;
					if (got.debounced_states !== want.debounced_states) begin
						$error("debounced_states: expected %02h, actual %02h",
							want.debounced_states, got.debounced_states);
						fails++;
					end
					if (got.changed_mask !== want.changed_mask) begin
						$error("changed_mask: expected %02h, actual %02h",
							want.changed_mask, got.changed_mask);
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(debounce_poll(s_tdata[TIME_W-1:0],
					s_tdata[TIME_W +: LEVEL_W]));
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the multi-channel input debouncer.
// ----------------------------------------------------------------------------
// Polls are sent as bursts with random gaps: a short directed sequence on the
// reset settings, then random bouncing inputs under several register
// settings, zero and full-scale delays and a shared limit channel among them.
// The receiver stalls on its own pattern and once holds off for a long
// stretch; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import mcid_pkg::*;

	localparam int SETTLE_CYCLES = 2 * CHANNELS + 4;
	localparam int HOLD_CYCLES   = 300;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata;   // now_ms[31:0], raw_levels[39:32]
	logic               m_tvalid;
	logic               m_tready;
	logic [OUT_W-1:0]   m_tdata;   // debounced_states[7:0], changed_mask[15:8]
	logic               cfg_wr_en;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_wdata;

	int fail_count;
	int pending_count;
	int checked_count;

	int polls_sent    = 0;
	int settings_used = 1;
	int burst_left    = 0;
	bit hold_rx       = 1'b0;

	always #5 clk = ~clk;

	multi_channel_input_debouncer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	mcid_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	// Receiver: a stall pattern drawn at random from four modes, plus a long
	// hold-off whenever the stimulus asks for one.
	initial begin
		int mode;
		int cyc;
		m_tready = 1'b0;
		mode = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end else begin
				cyc++;
				if (cyc % 64 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 4) == 0);
					default: m_tready <= (cyc % 8 < 3);
				endcase
			end
		end
	end

	task automatic offer_poll(input logic [TIME_W-1:0] now, input logic [LEVEL_W-1:0] levels);
		s_tdata  <= {levels, now};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		polls_sent++;
	endtask

	// Bursts of random length, separated by random gaps.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every outstanding poll has its result.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [LEVEL_W-1:0] nc, input logic [SEL_W-1:0] ext_ch,
			input logic [SEL_W-1:0] ret_ch, input logic [DELAY_W-1:0] ext_dly,
			input logic [DELAY_W-1:0] ret_dly, input logic [DELAY_W-1:0] btn_dly);
		cfg_index_t      idx [6];
		logic [CFG_W-1:0] val [6];
		idx = '{CFG_NC_MASK, CFG_EXTEND_CHANNEL, CFG_RETRACT_CHANNEL,
			CFG_EXTEND_DELAY, CFG_RETRACT_DELAY, CFG_BUTTON_DELAY};
		val = '{CFG_W'(nc), CFG_W'(ext_ch), CFG_W'(ret_ch), ext_dly, ret_dly, btn_dly};
		drain();
		for (int i = 0; i < 6; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// Random bouncing inputs; the time step is scaled to the delays so that
	// channels both settle and bounce. Half way through, the sender pauses
	// until every result is in.
	task automatic run_bounce(input int n, input int max_step, input bit long_hold);
		logic [TIME_W-1:0]  now;
		logic [LEVEL_W-1:0] levels;
		now = $urandom;
		levels = LEVEL_W'($urandom);
		if (long_hold)
			hold_rx = 1'b1;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0: now = $urandom;
				1: ;
				2: now += 4 * max_step + $urandom_range(0, max_step);
				default: now += $urandom_range(1, max_step);
			endcase
			if ($urandom_range(0, 15) == 0) begin
				levels = LEVEL_W'($urandom);
			end else begin
				for (int c = 0; c < LEVEL_W; c++)
					if ($urandom_range(0, 9) == 0)
						levels[c] = ~levels[c];
			end
			offer_poll(now, levels);
			if (i == n / 2)
				drain();
			else
				pace();
		end
	endtask

	function automatic int step_for(int a, int b, int c);
		int m;
		m = (a > b) ? a : b;
		m = (m > c) ? m : c;
		return m / 4 + 2;
	endfunction

	initial begin
		logic [TIME_W-1:0]  dir_now [16];
		logic [LEVEL_W-1:0] dir_lvl [16];
		logic [DELAY_W-1:0] ed;
		logic [DELAY_W-1:0] rd;
		logic [DELAY_W-1:0] bd;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_NC_MASK;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: limit channels at 10 ms, buttons at 50 ms, all
		// normally open. Includes the threshold edges and a timestamp wrap.
		dir_now = '{32'd0, 32'd0, 32'd10, 32'd11, 32'd50, 32'd51, 32'd52, 32'd58,
			32'd60, 32'd200, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd5, 32'd9, 32'd10, 32'd50};
		dir_lvl = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA, 8'h55,
			8'hAA, 8'hAA, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		for (int i = 0; i < 16; i++) begin
			offer_poll(dir_now[i], dir_lvl[i]);
			pace();
		end

		apply_settings(8'hFF, 3'd0, 3'd7, 16'd0, 16'd0, 16'd0);
		run_bounce(172, 2, 1'b0);

		// Both limit switches on one channel, full-scale delays.
		apply_settings(8'h00, 3'd3, 3'd3, 16'hFFFF, 16'd1, 16'hFFFF);
		run_bounce(172, step_for(65535, 1, 65535), 1'b1);

		apply_settings(8'hA5, 3'd7, 3'd0, 16'd5, 16'd20, 16'd12);
		run_bounce(172, step_for(5, 20, 12), 1'b0);

		for (int p = 0; p < 3; p++) begin
			ed = (p == 2) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 300));
			rd = 16'($urandom_range(0, 300));
			bd = 16'($urandom_range(0, 300));
			apply_settings(8'($urandom), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
				ed, rd, bd);
			run_bounce(172, step_for(ed, rd, bd), 1'b0);
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Summary: %0d polls under %0d register settings, %0d results checked.",
			polls_sent, settings_used, checked_count);
		$display("Covered bouncing inputs, timestamp wrap, zero and full-scale delays.");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Run timed out");
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== multi_channel_input_debouncer.f =====
sv/mcid_pkg.sv
sv/mcid_ram.sv
sv/multi_channel_input_debouncer.sv
sv/mcid_checker.sv
tb/mcid_checker.sv
tb/tb_top.sv
